// File: hw/rtl/queue_with_positional_insert_assert.svh
// ----------------------------------------------------------------------------
// Queue with positional insert: assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef QUEUE_WITH_POSITIONAL_INSERT_ASSERT_SVH
`define QUEUE_WITH_POSITIONAL_INSERT_ASSERT_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define QPI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue assertion failed");

// Antecedent implies consequent in the next cycle.
`define QPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue assertion failed");

`else

`define QPI_ASSERT_NOW(label, clk, rst, ante, cons)
`define QPI_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/qpi_pkg.sv
// ----------------------------------------------------------------------------
// Queue with positional insert: package
// Field widths, request opcodes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package qpi_pkg;

   localparam int OPCODE_W    = 2;
   localparam int POS_W       = 8;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   // Word returned by a pop that finds the queue empty.
   localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_INSERT = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/queue_with_positional_insert.sv
// ----------------------------------------------------------------------------
// Queue with positional insert
// Bounded ordered queue of signed words: push to tail, pop from head, insert
// at a 1-based position. Every entry decides its own next value in parallel.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  opcode, position, value
//   rsp_     out        rsp_valid / rsp_ready  popped_value, status, entry_count
//
// One request is taken per cycle; its response appears in the result register
// on the next cycle. The entry array and count update at the accepting edge.
// A request is taken whenever the result register is empty or being drained,
// so a stalled response holds back only the next request.
// Reset clears the count and the response valid; the entries are not cleared.
//
`default_nettype none

module queue_with_positional_insert #(
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [qpi_pkg::OPCODE_W-1:0]           req_opcode,
   input  wire logic [qpi_pkg::POS_W-1:0]              req_position,
   input  wire logic signed [qpi_pkg::DATA_W-1:0]      req_value,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [qpi_pkg::DATA_W-1:0]           rsp_popped_value,
   output logic [qpi_pkg::STATUS_W-1:0]                rsp_status,
   output logic [qpi_pkg::COUNT_OUT_W-1:0]             rsp_entry_count
);

   import qpi_pkg::*;

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

   logic signed [DATA_W-1:0] entries_ff [DEPTH];
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] popped_ff;
   logic signed [DATA_W-1:0] popped_in;
   status_type               status_ff;
   status_type               status_in;
   logic [COUNT_OUT_W-1:0]   entry_count_ff;

   logic                     accept;
   logic                     do_ins;
   logic                     do_pop;
   logic [CMPW-1:0]          slot;
   logic                     full;
   logic [CMPW-1:0]          pos_ext;
   logic [CMPW-1:0]          count_ext;

   // Handshake: the result register parts the two sides.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign full      = (count_ff == CW'(DEPTH));
   assign pos_ext   = CMPW'(req_position);
   assign count_ext = CMPW'(count_ff);

   // Decode the request against the current count.
   always_comb begin
      do_ins    = 1'b0;
      do_pop    = 1'b0;
      slot      = count_ext;
      popped_in = '0;
      status_in = ST_OK;
      unique case (req_opcode)
         OP_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         OP_POP: begin
            if (count_ff == '0) begin
               popped_in = EMPTY_WORD;
               status_in = ST_EMPTY;
            end else begin
               popped_in = entries_ff[0];
               do_pop    = 1'b1;
            end
         end
         OP_INSERT: begin
            slot = pos_ext - CMPW'(1);
            if ((pos_ext == '0) || (pos_ext > count_ext + CMPW'(1))) begin
               status_in = ST_BADPOS;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Next count follows the operation that really took place.
   always_comb begin
      count_in = count_ff;
      if (accept && do_ins) begin
         count_in = count_ff + CW'(1);
      end else if (accept && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Each entry picks its neighbor or the new word by comparing its index.
   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      logic signed [DATA_W-1:0] prev_word;
      logic signed [DATA_W-1:0] next_word;

      if (i == 0) begin : g_first
         assign prev_word = entries_ff[i];
      end else begin : g_rest
         assign prev_word = entries_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_word = entries_ff[i];
      end else begin : g_inner
         assign next_word = entries_ff[i+1];
      end

      always_ff @(posedge clock) begin
         if (accept && do_ins && (slot == CMPW'(i))) begin
            entries_ff[i] <= req_value;
         end else if (accept && do_ins && (slot < CMPW'(i))) begin
            entries_ff[i] <= prev_word;
         end else if (accept && do_pop) begin
            entries_ff[i] <= next_word;
         end
      end
   end

   // Response valid: set on accept, cleared when drained.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff      <= popped_in;
         status_ff      <= status_in;
         entry_count_ff <= COUNT_OUT_W'(count_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_status       = status_ff;
   assign rsp_entry_count  = entry_count_ff;

   // Assertions.
`include "queue_with_positional_insert_assert.svh"

   `QPI_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `QPI_ASSERT_NEXT(a_push_grows, clock, reset, accept && do_ins, count_ff == $past(count_ff) + CW'(1))
   `QPI_ASSERT_NOW(a_rsp_count, clock, reset, rsp_valid_ff, entry_count_ff == COUNT_OUT_W'(count_ff))
   `QPI_ASSERT_NOW(a_empty_word, clock, reset, rsp_valid_ff && (status_ff == ST_EMPTY), popped_ff == EMPTY_WORD)

endmodule

`default_nettype wire

// File: test/queue_with_positional_insert_test.sv
// ----------------------------------------------------------------------------
// Queue with positional insert: regression testbench
// Drives push, pop, positional-insert and unused-opcode requests with random
// gaps on both channels. A scoreboard keeps its own copy of the queue and
// checks every response beat field by field, in order.
// ----------------------------------------------------------------------------

module queue_with_positional_insert_test;

   timeunit 1ns;
   timeprecision 1ps;

   import qpi_pkg::*;

   localparam int QUEUE_DEPTH    = 16;
   localparam int RANDOM_ITEMS   = 400;
   localparam int CALM_ITEMS     = 60;
   localparam int CYCLE_LIMIT    = 100000;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   // One expected response beat.
   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      status_type               status;
      logic [COUNT_OUT_W-1:0]   entry_count;
   } queue_result_type;

   // Mirror of the queue contents plus the response beats still owed.
   class queue_mirror;
      logic signed [DATA_W-1:0] words [QUEUE_DEPTH];
      int unsigned              held;
      queue_result_type         awaited [$];
      int                       failures;

      function new();
         held = 0;
         failures = 0;
      endfunction

      function void flag(string msg);
         if (failures < REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
         end
         failures++;
      endfunction

      // Apply an accepted request to the mirror and queue up its response.
      function void note_request(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic signed [DATA_W-1:0] value);
         queue_result_type outcome;
         int unsigned      slot;
         outcome.popped_value = '0;
         outcome.status = ST_OK;
         case (op)
            OP_PUSH: begin
               if (held >= QUEUE_DEPTH) begin
                  outcome.status = ST_FULL;
               end else begin
                  words[held] = value;
                  held++;
               end
            end
            OP_POP: begin
               if (held == 0) begin
                  outcome.popped_value = EMPTY_WORD;
                  outcome.status = ST_EMPTY;
               end else begin
                  outcome.popped_value = words[0];
                  for (int i = 1; i < held; i++) begin
                     words[i-1] = words[i];
                  end
                  held--;
               end
            end
            OP_INSERT: begin
               // A bad position wins over a full queue.
               if (pos == 0 || pos > held + 1) begin
                  outcome.status = ST_BADPOS;
               end else if (held >= QUEUE_DEPTH) begin
                  outcome.status = ST_FULL;
               end else begin
                  slot = pos - 1;
                  for (int i = held; i > slot; i--) begin
                     words[i] = words[i-1];
                  end
                  words[slot] = value;
                  held++;
               end
            end
            default: begin
               // The unused opcode leaves everything as it is.
            end
         endcase
         outcome.entry_count = held[COUNT_OUT_W-1:0];
         awaited.push_back(outcome);
      endfunction

      // Compare one response beat with the oldest expectation.
      function void check_response(logic signed [DATA_W-1:0] popped,
                                   logic [STATUS_W-1:0] status,
                                   logic [COUNT_OUT_W-1:0] entries);
         queue_result_type want;
         if (awaited.size() == 0) begin
            flag($sformatf("unexpected response beat: value %0d status %0d count %0d",
                           popped, status, entries));
            return;
         end
         want = awaited.pop_front();
         if (popped !== want.popped_value) begin
            flag($sformatf("popped_value mismatch: expected %0d, got %0d",
                           want.popped_value, popped));
         end
         if (status !== want.status) begin
            flag($sformatf("status mismatch: expected %0d, got %0d",
                           want.status, status));
         end
         if (entries !== want.entry_count) begin
            flag($sformatf("entry_count mismatch: expected %0d, got %0d",
                           want.entry_count, entries));
         end
      endfunction

      function void flag_leftovers();
         if (awaited.size() != 0) begin
            flag($sformatf("%0d response beats never arrived", awaited.size()));
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [OPCODE_W-1:0]         req_opcode;
   logic [POS_W-1:0]            req_position;
   logic signed [DATA_W-1:0]    req_value;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [DATA_W-1:0]    rsp_popped_value;
   logic [STATUS_W-1:0]         rsp_status;
   logic [COUNT_OUT_W-1:0]      rsp_entry_count;

   bit                          calm;
   int                          cycle_count;
   queue_mirror                 mirror;

   queue_with_positional_insert #(
      .DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_popped_value(rsp_popped_value),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Cycle counter and response monitor, both sampling the pre-edge values.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         mirror.check_response(rsp_popped_value, rsp_status, rsp_entry_count);
      end
   end

   // Watchdog.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("queue_with_positional_insert regression: fail");
      $finish;
   end

   // Response side: random stalls, always ready once the run turns calm.
   initial begin : response_drain
      int span;
      rsp_ready <= 1'b0;
      repeat (3) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            span = $urandom_range(1, 10);
            rsp_ready <= 1'b0;
         end else begin
            span = $urandom_range(1, 20);
            rsp_ready <= 1'b1;
         end
         repeat (span) @(posedge clock);
      end
   end

   // Occasionally drop valid for a burst of cycles before the next beat.
   task automatic maybe_pause();
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Present one request beat and hold it until it is taken.
   task automatic send_request(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] value);
      maybe_pause();
      req_valid <= 1'b1;
      req_opcode <= op;
      req_position <= pos;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mirror.note_request(op, pos, value);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return -32'sd1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   // Random request, biased toward filling or draining the queue.
   task automatic send_random_request(bit filling);
      logic [OPCODE_W-1:0] op;
      logic [POS_W-1:0]    pos;
      int                  roll;
      int unsigned         level;
      level = mirror.held;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         op = OP_UNUSED;
      end else if (filling) begin
         op = (roll < 48) ? OP_PUSH : (roll < 88) ? OP_INSERT : OP_POP;
      end else begin
         op = (roll < 73) ? OP_POP : (roll < 85) ? OP_PUSH : OP_INSERT;
      end
      pos = POS_W'($urandom_range(0, 255));
      if (op == OP_INSERT) begin
         roll = $urandom_range(0, 9);
         if (roll < 7) begin
            pos = POS_W'($urandom_range(1, level + 1));
         end else if (roll == 7) begin
            pos = '0;
         end else if (roll == 8) begin
            pos = POS_W'($urandom_range(level + 2, 255));
         end
      end
      send_request(op, pos, pick_value());
   endtask

   // Main sequence.
   initial begin
      bit filling;
      mirror = new();
      calm = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_PUSH;
      req_position <= '0;
      req_value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pop, unused opcode, bad positions, inserts at head,
      // middle and tail, extreme words, then draining past empty.
      send_request(OP_POP, 8'd0, 32'sd0);
      send_request(OP_UNUSED, 8'd255, 32'sh8000_0000);
      send_request(OP_INSERT, 8'd0, 32'sd5);
      send_request(OP_INSERT, 8'd2, 32'sd6);
      send_request(OP_INSERT, 8'd255, 32'sd7);
      send_request(OP_INSERT, 8'd1, 32'sh8000_0000);
      send_request(OP_PUSH, 8'd255, 32'sh7FFF_FFFF);
      send_request(OP_INSERT, 8'd3, -32'sd1);
      send_request(OP_INSERT, 8'd2, 32'sd0);
      send_request(OP_INSERT, 8'd1, 32'sd1);
      send_request(OP_POP, 8'd255, -32'sd1);
      send_request(OP_INSERT, 8'd6, 32'sd9);
      send_request(OP_INSERT, 8'd5, 32'sh5555_AAAA);
      for (int i = 0; i < 7; i++) begin
         send_request(OP_POP, 8'd0, 32'sd0);
      end

      // Random sweeps between empty and full; the tail end runs without gaps.
      filling = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
         if (filling && mirror.held == QUEUE_DEPTH && $urandom_range(0, 2) == 0) begin
            filling = 1'b0;
         end else if (!filling && mirror.held == 0 && $urandom_range(0, 2) == 0) begin
            filling = 1'b1;
         end
         send_random_request(filling);
      end
      req_valid <= 1'b0;

      while (mirror.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      mirror.flag_leftovers();
      if (mirror.failures == 0) begin
         $display("queue_with_positional_insert regression: pass");
      end else begin
         $display("queue_with_positional_insert regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/qpi_pkg.sv
hw/rtl/queue_with_positional_insert.sv
test/queue_with_positional_insert_test.sv
